[design/lbp_pkg.sv]
`timescale 1ns / 1ps

package lbp_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int COL_BITS   = $clog2(MAX_WIDTH);
	localparam int PIXEL_BITS = 8;
	localparam int ENTRY_BITS = 2 * PIXEL_BITS;
	localparam int CODE_BITS  = 8;

	// configuration registers
	localparam int WIDTH_BITS     = 11;
	localparam int HEIGHT_BITS    = 16;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

	typedef logic [PIXEL_BITS-1:0] pixel_t;
	typedef logic [ENTRY_BITS-1:0] entry_t;
	typedef logic [COL_BITS-1:0]   col_t;

endpackage

[design/lbp_code_image_filter.sv]
`timescale 1ns / 1ps
// An accepted pixel beat passes the stage 1 registers, then the output register.
// Throughput: one pixel per cycle unless out_ready or the clearing pass stalls it;
// the line store has one read port and one write port, and the read of one column
// overlaps the write-back of the previous one. Reset: registers return to 640 x 480,
// the frame position to zero; a pass clears all 1024 entries while in_ready is low.

module lbp_code_image_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_wr_en,
	input  logic [lbp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [lbp_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
	// pixel stream in
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [lbp_pkg::PIXEL_BITS-1:0]       pixel,
	// code stream out
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [lbp_pkg::CODE_BITS-1:0]        code,
	output logic                                 code_valid,
	output logic                                 frame_last
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [lbp_pkg::WIDTH_BITS-1:0]  image_width_q;
	logic [lbp_pkg::HEIGHT_BITS-1:0] image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= lbp_pkg::WIDTH_RESET;
			image_height_q <= lbp_pkg::HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lbp_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata[lbp_pkg::WIDTH_BITS-1:0];
				lbp_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata[lbp_pkg::HEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Saturate the geometry: width into 1..MAX_WIDTH, height zero reads as one.
	logic [lbp_pkg::WIDTH_BITS-1:0]  w_eff;
	logic [lbp_pkg::HEIGHT_BITS-1:0] h_eff;

	always_comb begin
		if (image_width_q == '0) begin
			w_eff = lbp_pkg::WIDTH_BITS'(1);
		end else if (image_width_q > lbp_pkg::WIDTH_BITS'(lbp_pkg::MAX_WIDTH)) begin
			w_eff = lbp_pkg::WIDTH_BITS'(lbp_pkg::MAX_WIDTH);
		end else begin
			w_eff = image_width_q;
		end
		h_eff = (image_height_q == '0) ? lbp_pkg::HEIGHT_BITS'(1) : image_height_q;
	end

	// ------------------------------------------------------------------
	// Handshake and pipeline control
	// ------------------------------------------------------------------
	logic clearing_q;
	logic s1_valid_q;
	logic out_valid_q;
	logic s1_adv;
	logic accept;

	// s1 moves into the output register whenever that register is free or drained
	assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !clearing_q && (!s1_valid_q || s1_adv);
	assign accept   = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Frame position: column and row of the next pixel
	// ------------------------------------------------------------------
	lbp_pkg::col_t                   col_q;
	logic [lbp_pkg::HEIGHT_BITS-1:0] row_q;
	logic                            last_col;
	logic                            last_row;

	// a count at or past the last position ends the row or frame at once
	assign last_col = ({1'b0, col_q} + lbp_pkg::WIDTH_BITS'(1)) >= w_eff;
	assign last_row = ({1'b0, row_q} + (lbp_pkg::HEIGHT_BITS + 1)'(1)) >= {1'b0, h_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + lbp_pkg::HEIGHT_BITS'(1);
			end else begin
				col_q <= col_q + lbp_pkg::COL_BITS'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Clearing pass over the line store after reset
	// ------------------------------------------------------------------
	lbp_pkg::col_t clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + lbp_pkg::COL_BITS'(1);
			if (clr_addr_q == lbp_pkg::COL_BITS'(lbp_pkg::MAX_WIDTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: line store data returns, window shifts, entry written back
	// ------------------------------------------------------------------
	lbp_pkg::pixel_t pix_s1;
	lbp_pkg::col_t   col_s1;
	logic            full_s1;
	logic            last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel;
			col_s1  <= col_q;
			full_s1 <= (col_q >= lbp_pkg::COL_BITS'(2)) &&
			           (row_q >= lbp_pkg::HEIGHT_BITS'(2));
			last_s1 <= last_col && last_row;
		end
	end

	// Line store: entry holds row r-2 in the high half and row r-1 in the low half.
	lbp_pkg::entry_t ram_rdata;
	lbp_pkg::entry_t ram_wdata;
	lbp_pkg::col_t   ram_waddr;
	logic            ram_we;
	lbp_pkg::entry_t entry_s1;
	lbp_pkg::pixel_t top_s1;
	lbp_pkg::pixel_t mid_s1;

	// Forward the last write-back: a read issued on the same edge as a write
	// to the same column sees the old contents (width one).
	logic            fwd_valid_q;
	lbp_pkg::col_t   fwd_addr_q;
	lbp_pkg::entry_t fwd_data_q;

	assign entry_s1 = (fwd_valid_q && (fwd_addr_q == col_s1)) ? fwd_data_q : ram_rdata;
	assign top_s1   = entry_s1[lbp_pkg::ENTRY_BITS-1:lbp_pkg::PIXEL_BITS];
	assign mid_s1   = entry_s1[lbp_pkg::PIXEL_BITS-1:0];

	assign ram_we    = clearing_q || s1_adv;
	assign ram_waddr = clearing_q ? clr_addr_q : col_s1;
	assign ram_wdata = clearing_q ? '0 : {mid_s1, pix_s1};

	lbp_ram #(
		.WIDTH (lbp_pkg::ENTRY_BITS),
		.DEPTH (lbp_pkg::MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (s1_adv) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			fwd_addr_q <= col_s1;
			fwd_data_q <= ram_wdata;
		end
	end

	// Window: the two older columns, each as top, middle, bottom.
	// win_q[0..2] is column c-2, win_q[3..5] is column c-1.
	lbp_pkg::pixel_t win_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_s1;
			win_q[4] <= mid_s1;
			win_q[5] <= pix_s1;
		end
	end

	// Eight compares against the centre, clockwise from top-left.
	lbp_pkg::pixel_t                centre;
	logic [lbp_pkg::CODE_BITS-1:0] code_s1;

	always_comb begin
		centre     = win_q[4];
		code_s1[0] = win_q[0] >= centre;
		code_s1[1] = win_q[3] >= centre;
		code_s1[2] = top_s1   >= centre;
		code_s1[3] = mid_s1   >= centre;
		code_s1[4] = pix_s1   >= centre;
		code_s1[5] = win_q[5] >= centre;
		code_s1[6] = win_q[2] >= centre;
		code_s1[7] = win_q[1] >= centre;
		if (!full_s1) begin
			code_s1 = '0;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic [lbp_pkg::CODE_BITS-1:0] code_q;
	logic                          code_valid_q;
	logic                          frame_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			code_q       <= code_s1;
			code_valid_q <= full_s1;
			frame_last_q <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign code       = code_q;
	assign code_valid = code_valid_q;
	assign frame_last = frame_last_q;

endmodule

[design/lbp_ram.sv]
`timescale 1ns / 1ps

module lbp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/lbp_checker.sv]
`timescale 1ns / 1ps

module lbp_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [lbp_pkg::CODE_BITS-1:0]      code,
	input logic                               code_valid,
	input logic                               frame_last
);

	// hold a stalled code beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code) &&
		$stable(code_valid) && $stable(frame_last))
		else $error("code beat changed while stalled");

	// incomplete window gives the zero border
	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !code_valid |-> code == '0)
		else $error("nonzero code on incomplete window");

	// a code beat into an empty output comes from an accepted pixel beat through stage 1
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("code beat without matching pixel beat");

endmodule

bind lbp_code_image_filter lbp_checker u_lbp_checker (.*);
